>>> hw/rtl/fbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types, codes and sizing for the frustum box cull chain.
// ----------------------------------------------------------------------------
package fbc_pkg;

   localparam int FBC_VALUE_BITS = 32;
   localparam int FBC_FRAC_BITS  = 16;

   localparam int FBC_PLANES    = 6;
   localparam int FBC_AXES      = 3;
   localparam int FBC_CHAIN_LEN = FBC_PLANES * FBC_AXES;
   localparam int FBC_LAST_AXIS = FBC_AXES - 1;
   localparam int FBC_RSP_DEPTH = 32;

   localparam logic FBC_OP_LOAD = 1'b0;
   localparam logic FBC_OP_TEST = 1'b1;

   // column holding the plane offsets, row holding the shared plane base
   localparam logic [1:0] FBC_OFFSET_COL = 2'd3;
   localparam logic [1:0] FBC_BASE_ROW   = 2'd3;

   typedef struct packed {
      logic       valid;
      logic       op;
      logic [3:0] index;
      logic       visible;
   } ctrl_type;

   // exact width of offset plus three products
   function automatic int fbc_acc_width(input int value_bits, input int frac_bits);
      int prod_w;
      int offs_w;
      prod_w = 2 * value_bits + 1;
      offs_w = value_bits + 1 + frac_bits;
      return ((prod_w > offs_w) ? prod_w : offs_w) + 2;
   endfunction

endpackage

>>> hw/rtl/fbc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_cell
// One plane term: keeps its matrix elements, adds coef * corner to the
// running plane sum and hands the item to the next cell.
// ----------------------------------------------------------------------------
module fbc_cell #(
   parameter int VALUE_BITS = fbc_pkg::FBC_VALUE_BITS,
   parameter int FRAC_BITS  = fbc_pkg::FBC_FRAC_BITS,
   parameter int PLANE_AXIS = 0,
   parameter int PLANE_NEG  = 0,
   parameter int TERM_AXIS  = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fbc_pkg::ctrl_type                   ctrl_i,
   input  logic [VALUE_BITS-1:0]               value_i,
   input  logic [2:0][VALUE_BITS-1:0]          lo_i,
   input  logic [2:0][VALUE_BITS-1:0]          hi_i,
   input  logic [fbc_pkg::fbc_acc_width(VALUE_BITS, FRAC_BITS)-1:0] acc_i,
   output fbc_pkg::ctrl_type                   ctrl_o,
   output logic [VALUE_BITS-1:0]               value_o,
   output logic [2:0][VALUE_BITS-1:0]          lo_o,
   output logic [2:0][VALUE_BITS-1:0]          hi_o,
   output logic [fbc_pkg::fbc_acc_width(VALUE_BITS, FRAC_BITS)-1:0] acc_o
);
   import fbc_pkg::*;

   localparam int ACC_W  = fbc_acc_width(VALUE_BITS, FRAC_BITS);
   localparam int COEF_W = VALUE_BITS + 1;
   localparam int PROD_W = COEF_W + VALUE_BITS;

   // slot 0: this cell's axis column, slot 1: offset column
   localparam logic [1:0] SLOT_COL [2] = '{2'(TERM_AXIS), FBC_OFFSET_COL};

   logic [VALUE_BITS-1:0] base_ff [2];
   logic [VALUE_BITS-1:0] base_in [2];
   logic [VALUE_BITS-1:0] term_ff [2];
   logic [VALUE_BITS-1:0] term_in [2];
   logic [COEF_W-1:0]     coef_ff [2];
   logic [COEF_W-1:0]     coef_in [2];

   ctrl_type                  ctrl_ff, ctrl_in;
   logic [VALUE_BITS-1:0]     value_ff;
   logic [2:0][VALUE_BITS-1:0] lo_ff, hi_ff;
   logic [ACC_W-1:0]          acc_ff, acc_in;

   logic                      load_hit;
   logic                      coef_pos;
   logic signed [VALUE_BITS-1:0] corner;
   logic signed [COEF_W-1:0]  coef_axis;
   logic signed [PROD_W-1:0]  product;
   logic [ACC_W-1:0]          offset_acc;
   logic [ACC_W-1:0]          acc_base;

   assign load_hit = ctrl_i.valid && (ctrl_i.op == FBC_OP_LOAD);

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         base_in[j] = base_ff[j];
         term_in[j] = term_ff[j];
         if (load_hit && (ctrl_i.index[3:2] == SLOT_COL[j])) begin
            if (ctrl_i.index[1:0] == FBC_BASE_ROW) begin
               base_in[j] = value_i;
            end else if (ctrl_i.index[1:0] == 2'(PLANE_AXIS)) begin
               term_in[j] = value_i;
            end
         end
         if (PLANE_NEG != 0) begin
            coef_in[j] = {base_in[j][VALUE_BITS-1], base_in[j]}
                       - {term_in[j][VALUE_BITS-1], term_in[j]};
         end else begin
            coef_in[j] = {base_in[j][VALUE_BITS-1], base_in[j]}
                       + {term_in[j][VALUE_BITS-1], term_in[j]};
         end
      end
   end

   // corner picked by the normal sign: max where strictly positive
   assign coef_axis = $signed(coef_ff[0]);
   assign coef_pos  = !coef_ff[0][COEF_W-1] && (coef_ff[0] != '0);
   assign corner    = coef_pos ? $signed(hi_i[TERM_AXIS]) : $signed(lo_i[TERM_AXIS]);
   assign product   = coef_axis * corner;

   assign offset_acc = {{(ACC_W-COEF_W){coef_ff[1][COEF_W-1]}}, coef_ff[1]} << FRAC_BITS;
   assign acc_base   = (TERM_AXIS == 0) ? offset_acc : acc_i;
   assign acc_in     = acc_base + {{(ACC_W-PROD_W){product[PROD_W-1]}}, product};

   always_comb begin
      ctrl_in = ctrl_i;
      if ((TERM_AXIS == FBC_LAST_AXIS) && (ctrl_i.op == FBC_OP_TEST)) begin
         ctrl_in.visible = ctrl_i.visible & ~acc_in[ACC_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
         for (int j = 0; j < 2; j++) begin
            base_ff[j] <= '0;
            term_ff[j] <= '0;
            coef_ff[j] <= '0;
         end
      end else begin
         ctrl_ff <= ctrl_in;
         for (int j = 0; j < 2; j++) begin
            base_ff[j] <= base_in[j];
            term_ff[j] <= term_in[j];
            coef_ff[j] <= coef_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_i;
      lo_ff    <= lo_i;
      hi_ff    <= hi_i;
      acc_ff   <= acc_in;
   end

   assign ctrl_o  = ctrl_ff;
   assign value_o = value_ff;
   assign lo_o    = lo_ff;
   assign hi_o    = hi_ff;
   assign acc_o   = acc_ff;

endmodule

>>> hw/rtl/fbc_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_rsp_fifo
// Result queue behind the cell chain. Space is reserved at acceptance,
// so a push always finds room.
// ----------------------------------------------------------------------------
module fbc_rsp_fifo #(
   parameter int DEPTH = fbc_pkg::FBC_RSP_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push_i,
   input  logic push_data_i,
   input  logic pop_i,
   output logic data_o,
   output logic not_empty_o
);
   import fbc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic             mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign wr_ptr_in = push_i ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop_i ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_W'(push_i) - CNT_W'(pop_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   assign data_o      = mem_ff[rd_ptr_ff];
   assign not_empty_o = (count_ff != '0);

endmodule

>>> hw/rtl/frustum_box_cull.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_box_cull
// Six-plane frustum rejection of axis-aligned boxes in Q16.16, planes built
// from a 4x4 view-projection matrix that load items write element by element.
// ----------------------------------------------------------------------------
// Path: an accepted test item runs through the 18-cell chain (6 planes x
//   3 axes), one register per cell, into the result queue and rsp_valid.
// Throughput: one item per cycle; a 32-entry result queue sets how many
//   tests may be in flight before req_ready drops.
// Reset: clears the matrix, the chain's control fields and the result queue.
// ----------------------------------------------------------------------------
module frustum_box_cull #(
   parameter int VALUE_BITS = fbc_pkg::FBC_VALUE_BITS,
   parameter int FRAC_BITS  = fbc_pkg::FBC_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [3:0]            req_element_index,
   input  logic [VALUE_BITS-1:0] req_element_value,
   input  logic [VALUE_BITS-1:0] req_min_x,
   input  logic [VALUE_BITS-1:0] req_min_y,
   input  logic [VALUE_BITS-1:0] req_min_z,
   input  logic [VALUE_BITS-1:0] req_max_x,
   input  logic [VALUE_BITS-1:0] req_max_y,
   input  logic [VALUE_BITS-1:0] req_max_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_inside_res
);
   import fbc_pkg::*;

   localparam int ACC_W = fbc_acc_width(VALUE_BITS, FRAC_BITS);
   localparam int CNT_W = $clog2(FBC_RSP_DEPTH + 1);

   ctrl_type                   ctrl_chain  [0:FBC_CHAIN_LEN];
   logic [VALUE_BITS-1:0]      value_chain [0:FBC_CHAIN_LEN];
   logic [2:0][VALUE_BITS-1:0] lo_chain    [0:FBC_CHAIN_LEN];
   logic [2:0][VALUE_BITS-1:0] hi_chain    [0:FBC_CHAIN_LEN];
   logic [ACC_W-1:0]           acc_chain   [0:FBC_CHAIN_LEN];

   logic             req_accept;
   logic             test_accept;
   logic             rsp_pop;
   logic             result_push;
   logic [CNT_W-1:0] outstanding_ff, outstanding_in;

   assign req_accept  = req_valid && req_ready;
   assign test_accept = req_accept && (req_operation == FBC_OP_TEST);
   assign rsp_pop     = rsp_valid && rsp_ready;

   // tests in the chain plus results waiting in the queue
   assign req_ready      = (outstanding_ff < CNT_W'(FBC_RSP_DEPTH));
   assign outstanding_in = outstanding_ff + CNT_W'(test_accept) - CNT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   always_comb begin
      ctrl_chain[0].valid   = req_accept;
      ctrl_chain[0].op      = req_operation;
      ctrl_chain[0].index   = req_element_index;
      ctrl_chain[0].visible = 1'b1;
   end

   assign value_chain[0] = req_element_value;
   assign lo_chain[0]    = {req_min_z, req_min_y, req_min_x};
   assign hi_chain[0]    = {req_max_z, req_max_y, req_max_x};
   assign acc_chain[0]   = '0;

   for (genvar p = 0; p < FBC_PLANES; p++) begin : g_plane
      for (genvar a = 0; a < FBC_AXES; a++) begin : g_axis
         fbc_cell #(
            .VALUE_BITS (VALUE_BITS),
            .FRAC_BITS  (FRAC_BITS),
            .PLANE_AXIS (p / 2),
            .PLANE_NEG  (p % 2),
            .TERM_AXIS  (a)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl_i  (ctrl_chain[p*FBC_AXES+a]),
            .value_i (value_chain[p*FBC_AXES+a]),
            .lo_i    (lo_chain[p*FBC_AXES+a]),
            .hi_i    (hi_chain[p*FBC_AXES+a]),
            .acc_i   (acc_chain[p*FBC_AXES+a]),
            .ctrl_o  (ctrl_chain[p*FBC_AXES+a+1]),
            .value_o (value_chain[p*FBC_AXES+a+1]),
            .lo_o    (lo_chain[p*FBC_AXES+a+1]),
            .hi_o    (hi_chain[p*FBC_AXES+a+1]),
            .acc_o   (acc_chain[p*FBC_AXES+a+1])
         );
      end
   end

   assign result_push = ctrl_chain[FBC_CHAIN_LEN].valid
                     && (ctrl_chain[FBC_CHAIN_LEN].op == FBC_OP_TEST);

   fbc_rsp_fifo #(
      .DEPTH (FBC_RSP_DEPTH)
   ) u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_i      (result_push),
      .push_data_i (ctrl_chain[FBC_CHAIN_LEN].visible),
      .pop_i       (rsp_pop),
      .data_o      (rsp_inside_res),
      .not_empty_o (rsp_valid)
   );

   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= CNT_W'(FBC_RSP_DEPTH))
      else $error("outstanding test count above queue depth");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("result shown with no test outstanding");

   a_push_has_credit: assert property (@(posedge clock) disable iff (reset)
      result_push |-> (outstanding_ff != '0))
      else $error("chain delivered a test with no reserved queue slot");

   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      (outstanding_ff == CNT_W'(FBC_RSP_DEPTH)) |-> !req_ready)
      else $error("item taken while the result queue is committed");

endmodule

>>> bench/tb_frustum_box_cull.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_box_cull
// Self-checking bench for the frustum box cull. Load items fill a local copy
// of the view-projection matrix; each accepted test item is scored against an
// exact wide-integer plane evaluation and queued for in-order comparison.
// Directed cases cover the empty matrix, a degenerate frustum, the unit cube,
// and extreme values. Random streams follow under three idle profiles.
// ----------------------------------------------------------------------------
module tb_frustum_box_cull;

   import fbc_pkg::*;

   localparam int VW          = FBC_VALUE_BITS;
   localparam int FW          = FBC_FRAC_BITS;
   localparam int HALF_PERIOD = 5;
   localparam int SETTLE      = 40;

   localparam logic signed [VW-1:0] Q_ONE  = 1 <<< FW;
   localparam logic signed [VW-1:0] Q_HALF = 1 <<< (FW - 1);
   localparam logic signed [VW-1:0] V_MIN  = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [VW-1:0] V_MAX  = {1'b0, {(VW-1){1'b1}}};

   typedef struct packed {
      logic signed [VW-1:0] min_x;
      logic signed [VW-1:0] min_y;
      logic signed [VW-1:0] min_z;
      logic signed [VW-1:0] max_x;
      logic signed [VW-1:0] max_y;
      logic signed [VW-1:0] max_z;
   } box_type;

   logic          clock             = 1'b0;
   logic          reset             = 1'b1;
   logic          req_valid         = 1'b0;
   logic          req_ready;
   logic          req_operation     = FBC_OP_LOAD;
   logic [3:0]    req_element_index = '0;
   logic [VW-1:0] req_element_value = '0;
   logic [VW-1:0] req_min_x         = '0;
   logic [VW-1:0] req_min_y         = '0;
   logic [VW-1:0] req_min_z         = '0;
   logic [VW-1:0] req_max_x         = '0;
   logic [VW-1:0] req_max_y         = '0;
   logic [VW-1:0] req_max_z         = '0;
   logic          rsp_valid;
   logic          rsp_ready         = 1'b0;
   logic          rsp_inside_res;

   // local copy of the matrix, column*4+row
   logic signed [VW-1:0] view_proj [16];
   logic                 inside_expected_q [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int loads_sent    = 0;
   int tests_sent    = 0;
   int inside_seen   = 0;
   int culled_seen   = 0;

   frustum_box_cull i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_min_x         (req_min_x),
      .req_min_y         (req_min_y),
      .req_min_z         (req_min_z),
      .req_max_x         (req_max_x),
      .req_max_y         (req_max_y),
      .req_max_z         (req_max_z),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_inside_res    (rsp_inside_res)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // exact six-plane test against the current matrix copy
   function automatic logic predict_inside(input box_type b);
      logic signed [VW-1:0]  lo_c [3];
      logic signed [VW-1:0]  hi_c [3];
      logic signed [VW:0]    coef [4];
      logic signed [127:0]   plane_sum;
      logic                  keep_box;
      lo_c[0] = b.min_x;  lo_c[1] = b.min_y;  lo_c[2] = b.min_z;
      hi_c[0] = b.max_x;  hi_c[1] = b.max_y;  hi_c[2] = b.max_z;
      keep_box = 1'b1;
      for (int k = 0; k < 3; k++) begin
         for (int s = 0; s < 2; s++) begin
            for (int a = 0; a < 4; a++) begin
               if (s == 0) begin
                  coef[a] = view_proj[a*4+3] + view_proj[a*4+k];
               end else begin
                  coef[a] = view_proj[a*4+3] - view_proj[a*4+k];
               end
            end
            plane_sum = coef[3];
            plane_sum = plane_sum <<< FW;
            // positive normal picks the max corner, otherwise the min corner
            for (int a = 0; a < 3; a++) begin
               plane_sum = plane_sum + coef[a] * ((coef[a] > 0) ? hi_c[a] : lo_c[a]);
            end
            if (plane_sum < 0) keep_box = 1'b0;
         end
      end
      return keep_box;
   endfunction

   function automatic box_type make_box(input logic signed [VW-1:0] lx, ly, lz, hx, hy, hz);
      box_type b;
      b.min_x = lx;  b.min_y = ly;  b.min_z = lz;
      b.max_x = hx;  b.max_y = hy;  b.max_z = hz;
      return b;
   endfunction

   function automatic logic signed [VW-1:0] rand_fixed(input int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   // mix of full range, extremes and modest fixed-point values
   function automatic logic signed [VW-1:0] rand_wide();
      int pick;
      pick = $urandom_range(99);
      if (pick < 25) return $urandom;
      if (pick < 35) begin
         case ($urandom_range(3))
            0:       return V_MIN;
            1:       return V_MAX;
            2:       return '0;
            default: return '1;
         endcase
      end
      return rand_fixed(4 * Q_ONE);
   endfunction

   function automatic box_type rand_box();
      box_type              b;
      logic signed [VW-1:0] c, h;
      logic signed [VW-1:0] t;
      int                   pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         return make_box(rand_wide(), rand_wide(), rand_wide(),
                         rand_wide(), rand_wide(), rand_wide());
      end
      c = rand_fixed(3 * Q_ONE);  h = $urandom_range(3 * Q_HALF);
      b.min_x = c - h;  b.max_x = c + h;
      c = rand_fixed(3 * Q_ONE);  h = $urandom_range(3 * Q_HALF);
      b.min_y = c - h;  b.max_y = c + h;
      c = rand_fixed(3 * Q_ONE);  h = $urandom_range(3 * Q_HALF);
      b.min_z = c - h;  b.max_z = c + h;
      if (pick < 30) begin
         // inverted box, corners still picked by normal sign
         t = b.min_x;  b.min_x = b.max_x;  b.max_x = t;
         t = b.min_z;  b.min_z = b.max_z;  b.max_z = t;
      end
      return b;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < 20) $display("ERROR @%0t: %s", $time, what);
      error_count++;
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // sends one item; returns at the accepting edge with valid still high
   task automatic send_item(input logic op, input logic [3:0] idx,
                            input logic signed [VW-1:0] value, input box_type b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_element_index <= idx;
      req_element_value <= value;
      req_min_x         <= b.min_x;
      req_min_y         <= b.min_y;
      req_min_z         <= b.min_z;
      req_max_x         <= b.max_x;
      req_max_y         <= b.max_y;
      req_max_z         <= b.max_z;
      do @(posedge clock); while (!req_ready);
      if (op == FBC_OP_LOAD) begin
         view_proj[idx] = value;
         loads_sent++;
      end else begin
         inside_expected_q.push_back(predict_inside(b));
         tests_sent++;
      end
   endtask

   // unused fields get random content; they must be ignored
   task automatic load_element(input logic [3:0] idx, input logic signed [VW-1:0] value);
      send_item(FBC_OP_LOAD, idx, value, box_type'({$urandom, $urandom, $urandom,
                                                    $urandom, $urandom, $urandom}));
   endtask

   task automatic test_box(input box_type b);
      send_item(FBC_OP_TEST, 4'($urandom), $urandom, b);
   endtask

   // lower valid and hold off until every pending result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (inside_expected_q.size() != 0);
   endtask

   task automatic test_empty_matrix();
      // all planes zero: distance zero, never rejected
      test_box(make_box(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN));
   endtask

   task automatic test_degenerate_plane();
      // zero normals with negative offset reject everything
      load_element(4'd15, -Q_ONE);
      test_box(make_box(-Q_HALF, -Q_HALF, -Q_HALF, Q_HALF, Q_HALF, Q_HALF));
   endtask

   task automatic test_unit_cube();
      load_element(4'd15, Q_ONE);
      load_element(4'd0, Q_ONE);
      load_element(4'd5, Q_ONE);
      load_element(4'd10, Q_ONE);
      test_box(make_box(-Q_HALF, -Q_HALF, -Q_HALF, Q_HALF, Q_HALF, Q_HALF));
      test_box(make_box(3 * Q_HALF, 0, 0, 2 * Q_ONE, Q_HALF, Q_HALF));
      test_box(make_box(Q_HALF, 0, 0, 3 * Q_ONE, Q_HALF, Q_HALF));
      test_box(make_box(Q_HALF, Q_HALF, 2 * Q_ONE, -Q_HALF, -Q_HALF, 3 * Q_HALF));
      test_box(make_box(V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX));
      test_box(make_box(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN));
   endtask

   task automatic test_value_extremes();
      load_element(4'd3, V_MIN);
      load_element(4'd12, V_MAX);
      load_element(4'd1, '1);
      test_box(make_box(V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX));
      test_box(make_box(V_MAX, V_MAX, V_MAX, V_MIN, V_MIN, V_MIN));
   endtask

   task automatic load_random_matrix();
      int style;
      style = $urandom_range(9);
      for (int i = 0; i < 16; i++) begin
         if (style < 5) begin
            // perturbed identity keeps the frustum near the unit cube
            if (i % 5 == 0) load_element(4'(i), Q_HALF + $urandom_range(3 * Q_HALF));
            else            load_element(4'(i), rand_fixed(Q_ONE / 4));
         end else if (style < 8) begin
            load_element(4'(i), rand_fixed(2 * Q_ONE));
         end else begin
            load_element(4'(i), rand_wide());
         end
      end
   endtask

   task automatic test_random_stream(input int n_items);
      int start;
      int pick;
      int burst;
      logic paused;
      start  = loads_sent + tests_sent;
      paused = 1'b0;
      while (loads_sent + tests_sent - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            load_random_matrix();
         end else if (pick < 25) begin
            load_element(4'($urandom), rand_wide());
         end else begin
            burst = $urandom_range(1, 12);
            repeat (burst) test_box(rand_box());
         end
         if (!paused && loads_sent + tests_sent - start > n_items / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin : result_check
      logic want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (inside_expected_q.size() == 0) begin
            report_mismatch("result with no pending test item");
         end else begin
            want = inside_expected_q.pop_front();
            if (rsp_inside_res !== want) begin
               report_mismatch($sformatf("inside_res got %b expected %b",
                                         rsp_inside_res, want));
            end
            if (want) inside_seen++;
            else      culled_seen++;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      for (int i = 0; i < 16; i++) view_proj[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idle(32, 86);
      test_empty_matrix();
      test_degenerate_plane();
      test_unit_cube();
      test_value_extremes();
      test_random_stream(330);

      set_idle(86, 32);
      test_random_stream(330);

      set_idle(0, 0);
      test_random_stream(340);

      drain_results();
      repeat (SETTLE) @(posedge clock);

      $display("Ran %0d matrix loads and %0d box tests (%0d inside, %0d culled)",
               loads_sent, tests_sent, inside_seen, culled_seen);
      $display("under slow-sender, slow-receiver and back-to-back traffic.");
      if (error_count == 0 && inside_expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
